@@ rtl/hmp_pkg.sv @@
// Package for the hex memory file parser: constants, codes and character decode.
`default_nettype none
package hmp_pkg;

	localparam int MAX_DIGITS = 16;
	localparam int ADDR_BITS  = 32;

	localparam int WORD_W  = 64;
	localparam int COUNT_W = 5;
	localparam int ADDR_W  = 32;
	localparam int CODE_W  = 3;
	localparam int HELD_W  = $clog2(MAX_DIGITS + 1);

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UZ    = 8'h5a;

	typedef enum logic [CODE_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_BAD_CHAR = 3'd1,
		ERR_MISPLACED_AT = 3'd2,
		ERR_ADDR_GAP = 3'd3,
		ERR_OVERFLOW = 3'd4
	} err_code_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.value = 4'(c - 8'h37);
		end else if (c == CH_LX || c == CH_UX || c == CH_LZ || c == CH_UZ) begin
			d.value = 4'd0;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

@@ rtl/hmp_if.sv @@
// Valid/ready channel interfaces for characters in and parsed words out.
`default_nettype none
interface hmp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       line_end;

	modport source (output valid, output character, output line_end, input ready);
	modport sink (input valid, input character, input line_end, output ready);
endinterface

interface hmp_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_value;
	logic [4:0]  digit_count;
	logic [31:0] word_address;
	logic [2:0]  error_code;

	modport source (output valid, output word_value, output digit_count,
		output word_address, output error_code, input ready);
	modport sink (input valid, input word_value, input digit_count,
		input word_address, input error_code, output ready);
endinterface
`default_nettype wire

@@ rtl/hex_memory_file_parser.sv @@
// Top level of the hex memory file parser: input stage, token logic, result register.
//
//   channel | dir | payload                                          | handshake
//   chars   | in  | character, line_end                              | valid/ready
//   words   | out | word_value, digit_count, word_address, error_code | valid/ready
//
// One character per cycle unless stalled; words go from input stage to the result register.
// Token state updates as the registered character passes to the result register.
// Reset clears all token state and the sticky error; after an error no word leaves.
// A stalled result register holds only characters that would produce a word.
`default_nettype none
module hex_memory_file_parser import hmp_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	hmp_char_if.sink    chars,
	hmp_word_if.source  words
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 eol_s1;

	logic [WORD_W-1:0]    acc_q;
	logic [HELD_W-1:0]    held_q;
	logic                 in_addr_q;
	logic [ADDR_BITS-1:0] exp_addr_q;
	logic                 stuck_q;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic [ADDR_W-1:0]    out_addr_q;
	err_code_t            out_code_q;

	logic                 has_res;
	logic [WORD_W-1:0]    res_word;
	logic [COUNT_W-1:0]   res_count;
	err_code_t            res_code;
	logic [WORD_W-1:0]    acc_d;
	logic [HELD_W-1:0]    held_d;
	logic                 in_addr_d;
	logic [ADDR_BITS-1:0] exp_addr_d;
	logic                 stuck_d;
	logic                 advance;
	hex_digit_t           dig;

	always_comb begin
		dig        = hex_decode(char_s1);
		has_res    = 1'b0;
		res_word   = '0;
		res_count  = '0;
		res_code   = ERR_NONE;
		acc_d      = acc_q;
		held_d     = held_q;
		in_addr_d  = in_addr_q;
		exp_addr_d = exp_addr_q;
		stuck_d    = stuck_q;
		if (!stuck_q) begin
			if (eol_s1 || char_s1 == CH_SPACE || char_s1 == CH_TAB || char_s1 == CH_CR) begin
				if (in_addr_q && acc_q != WORD_W'(exp_addr_q)) begin
					has_res  = 1'b1;
					res_code = ERR_ADDR_GAP;
					stuck_d  = 1'b1;
				end else begin
					if (!in_addr_q && held_q != '0) begin
						has_res    = 1'b1;
						res_word   = acc_q;
						res_count  = COUNT_W'(held_q);
						exp_addr_d = exp_addr_q + 1'b1;
					end
					acc_d     = '0;
					held_d    = '0;
					in_addr_d = 1'b0;
				end
			end else if (dig.ok) begin
				if (held_q >= HELD_W'(MAX_DIGITS)) begin
					has_res  = 1'b1;
					res_code = ERR_OVERFLOW;
					stuck_d  = 1'b1;
				end else begin
					acc_d  = {acc_q[WORD_W-5:0], dig.value};
					held_d = held_q + 1'b1;
				end
			end else if (char_s1 == CH_UNDER) begin
				acc_d = acc_q;
			end else if (char_s1 == CH_AT) begin
				if (in_addr_q || held_q != '0) begin
					has_res  = 1'b1;
					res_code = ERR_MISPLACED_AT;
					stuck_d  = 1'b1;
				end else begin
					in_addr_d = 1'b1;
				end
			end else begin
				has_res  = 1'b1;
				res_code = ERR_BAD_CHAR;
				stuck_d  = 1'b1;
			end
		end
	end

	assign advance     = valid_s1 && (!has_res || !out_valid_q || words.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.character;
			eol_s1  <= chars.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			held_q     <= '0;
			in_addr_q  <= 1'b0;
			exp_addr_q <= '0;
			stuck_q    <= 1'b0;
		end else if (advance) begin
			acc_q      <= acc_d;
			held_q     <= held_d;
			in_addr_q  <= in_addr_d;
			exp_addr_q <= exp_addr_d;
			stuck_q    <= stuck_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_word_q  <= res_word;
			out_count_q <= res_count;
			out_addr_q  <= ADDR_W'(exp_addr_q);
			out_code_q  <= res_code;
		end
	end

	assign words.valid        = out_valid_q;
	assign words.word_value   = out_word_q;
	assign words.digit_count  = out_count_q;
	assign words.word_address = out_addr_q;
	assign words.error_code   = out_code_q;

endmodule
`default_nettype wire

@@ tb/tb_hex_memory_file_parser.sv @@
// Self-checking testbench for the hex memory file parser: random hex text, stalls, word checks.
`timescale 1ns / 1ps
module tb_hex_memory_file_parser import hmp_pkg::*; ();

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_EVERY = 400;
	localparam int TEXT_ITEMS = 1170;

	typedef struct packed {
		logic [7:0] character;
		logic       line_end;
	} text_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  value;
		logic [COUNT_W-1:0] count;
		logic [ADDR_W-1:0]  addr;
		err_code_t          code;
	} word_t;

	logic clk;
	logic arst_n;

	hmp_char_if chars_if ();
	hmp_word_if words_if ();

	hex_memory_file_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.words  (words_if)
	);

	text_item_t text_q[$];
	word_t      pending_words[$];

	// parser state as predicted
	logic [WORD_W-1:0] tok_value;
	logic [4:0]        tok_digits;
	bit                tok_is_addr;
	logic [ADDR_W-1:0] next_addr;
	bit                halted;
	err_code_t         fault_seen;

	int mismatches;
	int chars_taken;
	int words_seen;
	int hold_left;
	int hold_cycles_total;
	int next_hold_at;
	int quiet_cycles;
	int src_gap;
	int snk_gap;
	bit src_calm;
	bit snk_calm;
	logic [ADDR_W-1:0] gen_addr;
	text_item_t drive_item;
	word_t got_word;
	word_t want_word;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c == CH_LX || c == CH_UX || c == CH_LZ || c == CH_UZ) return 0;
		return -1;
	endfunction

	function automatic void expect_word(word_t w);
		pending_words = {pending_words, w};
	endfunction

	function automatic void queue_item(text_item_t t);
		text_q = {text_q, t};
	endfunction

	function automatic void flag_fault(err_code_t code);
		word_t w;
		w.value = '0;
		w.count = '0;
		w.addr = next_addr;
		w.code = code;
		expect_word(w);
		halted = 1'b1;
		fault_seen = code;
	endfunction

	function automatic void close_token();
		word_t w;
		if (tok_is_addr) begin
			if (tok_value != {{(WORD_W-ADDR_W){1'b0}}, next_addr}) begin
				flag_fault(ERR_ADDR_GAP);
				return;
			end
		end else if (tok_digits != 0) begin
			w.value = tok_value;
			w.count = tok_digits;
			w.addr = next_addr;
			w.code = ERR_NONE;
			expect_word(w);
			next_addr = next_addr + 1'b1;
		end
		tok_value = '0;
		tok_digits = '0;
		tok_is_addr = 1'b0;
	endfunction

	function automatic void parse_char(logic [7:0] c, logic eol);
		int d;
		if (halted) return;
		if (eol) begin
			close_token();
			return;
		end
		d = nibble_of(c);
		if (d >= 0) begin
			if (tok_digits >= MAX_DIGITS) begin
				flag_fault(ERR_OVERFLOW);
			end else begin
				tok_value = {tok_value[WORD_W-5:0], d[3:0]};
				tok_digits = tok_digits + 1'b1;
			end
		end else if (c == CH_UNDER) begin
		end else if (c == CH_AT) begin
			if (tok_is_addr || tok_digits != 0) flag_fault(ERR_MISPLACED_AT);
			else tok_is_addr = 1'b1;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
			close_token();
		end else begin
			flag_fault(ERR_BAD_CHAR);
		end
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < 40)
			$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void add_char(logic [7:0] c);
		text_item_t t;
		t.character = c;
		t.line_end = 1'b0;
		queue_item(t);
	endfunction

	function automatic void add_eol();
		text_item_t t;
		t.character = 8'($urandom_range(0, 255));
		t.line_end = 1'b1;
		queue_item(t);
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] n);
		logic [7:0] c;
		if (n == 0 && $urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: c = CH_LX;
				1: c = CH_UX;
				2: c = CH_LZ;
				default: c = CH_UZ;
			endcase
		end else if (n < 10) begin
			c = "0" + 8'(n);
		end else if ($urandom_range(0, 1) == 0) begin
			c = "a" + 8'(n - 10);
		end else begin
			c = "A" + 8'(n - 10);
		end
		return c;
	endfunction

	function automatic void add_separator();
		case ($urandom_range(0, 3))
			0: add_char(CH_SPACE);
			1: add_char(CH_TAB);
			2: add_char(CH_CR);
			default: add_eol();
		endcase
	endfunction

	function automatic void add_number(logic [63:0] v, int n);
		for (int i = n - 1; i >= 0; i--) begin
			if ($urandom_range(0, 7) == 0) add_char(CH_UNDER);
			add_char(digit_char(v[4*i +: 4]));
		end
	endfunction

	function automatic int digits_for(logic [ADDR_W-1:0] a);
		int n;
		n = 1;
		while (n < 8 && (a >> (4 * n)) != 0) n++;
		return n;
	endfunction

	function automatic void add_fault_tail();
		err_code_t pick;
		logic [7:0] c;
		logic [63:0] v;
		pick = err_code_t'($urandom_range(1, 4));
		case (pick)
			ERR_BAD_CHAR: begin
				if ($urandom_range(0, 1) == 0) add_number({$urandom, $urandom}, 3);
				do c = 8'($urandom_range(0, 255));
				while (nibble_of(c) >= 0 || c == CH_UNDER || c == CH_AT || c == CH_SPACE
					|| c == CH_TAB || c == CH_CR);
				add_char(c);
			end
			ERR_MISPLACED_AT: begin
				if ($urandom_range(0, 1) == 0) add_char(CH_AT);
				else add_number({$urandom, $urandom}, $urandom_range(1, 4));
				add_char(CH_AT);
			end
			ERR_ADDR_GAP: begin
				add_char(CH_AT);
				if ($urandom_range(0, 1) == 0) begin
					v = {32'd0, gen_addr + 32'($urandom_range(1, 1000))};
					add_number(v, 8);
				end else begin
					v = {32'($urandom) | 32'd1, gen_addr};
					add_number(v, 16);
				end
				add_separator();
			end
			default: begin
				if ($urandom_range(0, 1) == 0) add_char(CH_AT);
				add_number({$urandom, $urandom}, 16);
				add_char(digit_char(4'($urandom_range(0, 15))));
			end
		endcase
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 1) == 0) add_eol();
			else add_char(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void build_text();
		int pad;
		// lone address mark at zero, empty line, mixed digits, address closed by end of line
		add_char(CH_AT);
		add_char(CH_SPACE);
		add_eol();
		add_char(CH_LX);
		add_char(CH_UZ);
		add_char(CH_UNDER);
		add_char("a");
		add_char(CH_TAB);
		add_char(CH_AT);
		add_char("0");
		add_char(CH_UNDER);
		add_char("1");
		add_eol();
		for (int i = 0; i < 16; i++) add_char("F");
		add_char(CH_CR);
		add_char("0");
		add_char(CH_SPACE);
		gen_addr = 3;
		while (text_q.size() < TEXT_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				pad = $urandom_range(0, 3);
				add_char(CH_AT);
				add_number({32'd0, gen_addr}, digits_for(gen_addr) + pad);
				add_separator();
			end else begin
				add_number({$urandom, $urandom}, $urandom_range(1, 16));
				add_separator();
				gen_addr++;
			end
			if ($urandom_range(0, 5) == 0) add_separator();
		end
		add_fault_tail();
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.character <= '0;
			chars_if.line_end <= 1'b0;
			chars_taken <= 0;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				parse_char(chars_if.character, chars_if.line_end);
				chars_taken <= chars_taken + 1;
				if (chars_taken % 96 == 0) src_calm = ($urandom_range(0, 3) == 0);
				if (src_calm) src_gap = 0;
				else if ($urandom_range(0, 3) == 0) src_gap = $urandom_range(0, 18);
				else src_gap = $urandom_range(0, 1);
			end
			if (!chars_if.valid || chars_if.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					chars_if.valid <= 1'b0;
				end else if (text_q.size() != 0) begin
					drive_item = text_q.pop_front();
					chars_if.character <= drive_item.character;
					chars_if.line_end <= drive_item.line_end;
					chars_if.valid <= 1'b1;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= HOLD_EVERY;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			hold_cycles_total++;
		end else if (chars_taken >= next_hold_at) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_EVERY;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_if.ready <= 1'b0;
		end else begin
			if (words_if.valid && words_if.ready) begin
				got_word.value = words_if.word_value;
				got_word.count = words_if.digit_count;
				got_word.addr = words_if.word_address;
				got_word.code = err_code_t'(words_if.error_code);
				words_seen++;
				if (pending_words.size() == 0) begin
					report_mismatch("word with nothing expected", got_word.value, '0);
				end else begin
					want_word = pending_words.pop_front();
					if (got_word.value !== want_word.value)
						report_mismatch("word_value", got_word.value, want_word.value);
					if (got_word.count !== want_word.count)
						report_mismatch("digit_count", 64'(got_word.count), 64'(want_word.count));
					if (got_word.addr !== want_word.addr)
						report_mismatch("word_address", 64'(got_word.addr), 64'(want_word.addr));
					if (got_word.code !== want_word.code)
						report_mismatch("error_code", 64'(got_word.code), 64'(want_word.code));
				end
				if (words_seen % 16 == 0) snk_calm = ($urandom_range(0, 3) == 0);
				if (snk_calm) snk_gap = 0;
				else if ($urandom_range(0, 2) == 0) snk_gap = $urandom_range(0, 18);
				else snk_gap = $urandom_range(0, 2);
			end else if (snk_gap != 0) begin
				snk_gap--;
			end
			words_if.ready <= (snk_gap == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((chars_if.valid && chars_if.ready) || (words_if.valid && words_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= IDLE_LIMIT);
		$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.character = '0;
		chars_if.line_end = 1'b0;
		words_if.ready = 1'b0;
		tok_value = '0;
		tok_digits = '0;
		tok_is_addr = 1'b0;
		next_addr = '0;
		halted = 1'b0;
		fault_seen = ERR_NONE;
		mismatches = 0;
		words_seen = 0;
		hold_cycles_total = 0;
		src_gap = 0;
		snk_gap = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		build_text();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (text_q.size() != 0 || chars_if.valid);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d characters and %0d words, with %0d cycles of output hold-off",
			chars_taken, words_seen, hold_cycles_total);
		$display("stream closed on fault %s at address 0x%0h", fault_seen.name(), next_addr);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ hex_memory_file_parser.f @@
rtl/hmp_pkg.sv
rtl/hmp_if.sv
rtl/hex_memory_file_parser.sv
tb/tb_hex_memory_file_parser.sv
